// ===== rtl/vohist_pkg.sv =====
// ----------------------------------------------------------------------------
// vohist_pkg
// shared types and constants of the voxel occupancy histogram unit
// ----------------------------------------------------------------------------
package vohist_pkg;

  localparam int MAX_CELLS  = 4096;
  localparam int CELL_AW    = $clog2(MAX_CELLS);
  localparam int COUNT_BITS = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] MODE_MARK  = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [2:0] REG_PIVOT_X  = 3'd0;
  localparam logic [2:0] REG_PIVOT_Y  = 3'd1;
  localparam logic [2:0] REG_PIVOT_Z  = 3'd2;
  localparam logic [2:0] REG_CELL_INV = 3'd3;
  localparam logic [2:0] REG_CELLS_X  = 3'd4;
  localparam logic [2:0] REG_CELLS_Y  = 3'd5;
  localparam logic [2:0] REG_CELLS_Z  = 3'd6;

  typedef struct packed {
    logic                  occupied;
    logic [COUNT_BITS-1:0] count;
  } cell_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [CELL_AW-1:0] addr;
    cell_t              wdata;
  } store_req_t;

endpackage

// ===== rtl/voxel_occupancy_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_occupancy_histogram_unit
// bins Q16.8 points into a voxel grid and keeps occupancy and keypoint counts
// ----------------------------------------------------------------------------
// Each point is worked through in full before the next point is taken, and
// the cell store access is skipped when its linear index falls outside the
// grid: one shared signed multiplier does the three axis scalings, the plane
// size, the index terms and the grid size, one product per cycle, followed by
// a range check and a read-modify-write of the cell store. The finished result
// moves into an output register, so the next point is taken while it waits; a
// further result that finishes while that register is still full holds the
// block until the register empties. After reset the cell store is swept to
// zero, one entry per cycle, through all 4096 entries before the first point
// is taken. Configuration writes take effect at once and belong between
// points, while no point is in flight.
module voxel_occupancy_histogram_unit
  import vohist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // mode[1:0], pos_x[25:2], pos_y[49:26], pos_z[73:50], zero fill
  input  logic [79:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_index[11:0], in_range[12], occupied[13], keypoint_count[29:14], zero fill
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MX   = 4'd1;
  localparam logic [3:0] ST_MY   = 4'd2;
  localparam logic [3:0] ST_MZ   = 4'd3;
  localparam logic [3:0] ST_MNXY = 4'd4;
  localparam logic [3:0] ST_MXY  = 4'd5;
  localparam logic [3:0] ST_MXYZ = 4'd6;
  localparam logic [3:0] ST_MTOT = 4'd7;
  localparam logic [3:0] ST_CHK  = 4'd8;
  localparam logic [3:0] ST_RMW  = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  localparam int PROD_W  = 50;
  localparam int COORD_W = 26;
  localparam int IDX_W   = 38;

  // configuration registers
  logic signed [23:0] pivot_x_r, pivot_y_r, pivot_z_r;
  logic [23:0]        cell_inv_r;
  logic [4:0]         cells_x_r, cells_y_r, cells_z_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // sequencer and datapath
  logic [3:0]                state_r, state_nxt;
  logic [1:0]                mode_r;
  logic signed [23:0]        pos_x_r, pos_y_r, pos_z_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [9:0]                nxy_r;
  logic signed [IDX_W-1:0]   idx_r;
  logic [CELL_AW-1:0]        addr_r;
  logic [11:0]               res_index_r;
  logic                      res_range_r;
  cell_t                     res_cell_r;

  logic                      out_valid_r;
  logic [31:0]               out_data_r;

  logic signed [24:0]        diff;
  logic signed [26:0]        mul_a;
  logic signed [24:0]        mul_b;
  logic signed [51:0]        mul_p;
  logic [4:0]                half_cells;
  logic signed [PROD_W-1:0]  coord_sum;
  logic signed [COORD_W-1:0] coord;
  logic                      idx_ok;
  logic                      out_free;
  cell_t                     cell_new;

  store_req_t                st_req;
  cell_t                     st_rdata;
  logic                      st_busy;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_x_r  <= '0;
      pivot_y_r  <= '0;
      pivot_z_r  <= '0;
      cell_inv_r <= 24'd65536;
      cells_x_r  <= 5'd16;
      cells_y_r  <= 5'd16;
      cells_z_r  <= 5'd16;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PIVOT_X:  pivot_x_r  <= cfg_pwdata[23:0];
        REG_PIVOT_Y:  pivot_y_r  <= cfg_pwdata[23:0];
        REG_PIVOT_Z:  pivot_z_r  <= cfg_pwdata[23:0];
        REG_CELL_INV: cell_inv_r <= cfg_pwdata[23:0];
        REG_CELLS_X:  cells_x_r  <= cfg_pwdata[4:0];
        REG_CELLS_Y:  cells_y_r  <= cfg_pwdata[4:0];
        REG_CELLS_Z:  cells_z_r  <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PIVOT_X:  cfg_prdata = {8'd0, pivot_x_r};
      REG_PIVOT_Y:  cfg_prdata = {8'd0, pivot_y_r};
      REG_PIVOT_Z:  cfg_prdata = {8'd0, pivot_z_r};
      REG_CELL_INV: cfg_prdata = {8'd0, cell_inv_r};
      REG_CELLS_X:  cfg_prdata = {27'd0, cells_x_r};
      REG_CELLS_Y:  cfg_prdata = {27'd0, cells_y_r};
      REG_CELLS_Z:  cfg_prdata = {27'd0, cells_z_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    diff       = '0;
    mul_a      = '0;
    mul_b      = '0;
    half_cells = cells_x_r;
    case (state_r)
      ST_MX: begin
        diff  = {pos_x_r[23], pos_x_r} - {pivot_x_r[23], pivot_x_r};
        mul_a = {{2{diff[24]}}, diff};
        mul_b = {1'b0, cell_inv_r};
      end
      ST_MY: begin
        diff       = {pos_y_r[23], pos_y_r} - {pivot_y_r[23], pivot_y_r};
        mul_a      = {{2{diff[24]}}, diff};
        mul_b      = {1'b0, cell_inv_r};
        half_cells = cells_x_r;
      end
      ST_MZ: begin
        diff       = {pos_z_r[23], pos_z_r} - {pivot_z_r[23], pivot_z_r};
        mul_a      = {{2{diff[24]}}, diff};
        mul_b      = {1'b0, cell_inv_r};
        half_cells = cells_y_r;
      end
      ST_MNXY: begin
        mul_a      = {22'd0, cells_x_r};
        mul_b      = {20'd0, cells_y_r};
        half_cells = cells_z_r;
      end
      ST_MXY: begin
        mul_a = {cy_r[COORD_W-1], cy_r};
        mul_b = {20'd0, cells_x_r};
      end
      ST_MXYZ: begin
        mul_a = {cz_r[COORD_W-1], cz_r};
        mul_b = {15'd0, nxy_r};
      end
      ST_MTOT: begin
        mul_a = {17'd0, nxy_r};
        mul_b = {20'd0, cells_z_r};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // floor(prod / 2^24 + cells/2)
  assign coord_sum = prod_r + {{(PROD_W-28){1'b0}}, half_cells, 23'd0};
  assign coord     = coord_sum[PROD_W-1:24];

  assign idx_ok = !idx_r[IDX_W-1]
                  && (idx_r < prod_r[IDX_W-1:0])
                  && (idx_r < IDX_W'(MAX_CELLS));

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    cell_new = st_rdata;
    if (mode_r == MODE_MARK) begin
      cell_new.occupied = 1'b1;
    end else if (mode_r == MODE_COUNT && st_rdata.count != COUNT_MAX) begin
      cell_new.count = st_rdata.count + 1'b1;
    end
  end

  always_comb begin
    st_req.rd_en = (state_r == ST_CHK) && idx_ok;
    st_req.wr_en = (state_r == ST_RMW);
    st_req.addr  = (state_r == ST_CHK) ? idx_r[CELL_AW-1:0] : addr_r;
    st_req.wdata = cell_new;
  end

  assign in_tready = (state_r == ST_IDLE) && !st_busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid && in_tready) state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_MZ;
      ST_MZ:   state_nxt = ST_MNXY;
      ST_MNXY: state_nxt = ST_MXY;
      ST_MXY:  state_nxt = ST_MXYZ;
      ST_MXYZ: state_nxt = ST_MTOT;
      ST_MTOT: state_nxt = ST_CHK;
      ST_CHK:  state_nxt = idx_ok ? ST_RMW : ST_DONE;
      ST_RMW:  state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r  <= in_tdata[1:0];
      pos_x_r <= in_tdata[25:2];
      pos_y_r <= in_tdata[49:26];
      pos_z_r <= in_tdata[73:50];
    end
    prod_r <= mul_p[PROD_W-1:0];
    case (state_r)
      ST_MY:   cx_r <= coord;
      ST_MZ:   cy_r <= coord;
      ST_MNXY: cz_r <= coord;
      ST_MXY: begin
        nxy_r <= prod_r[9:0];
        idx_r <= {{(IDX_W-COORD_W){cx_r[COORD_W-1]}}, cx_r};
      end
      ST_MXYZ: idx_r <= idx_r + prod_r[IDX_W-1:0];
      ST_MTOT: idx_r <= idx_r + prod_r[IDX_W-1:0];
      ST_CHK: begin
        addr_r      <= idx_r[CELL_AW-1:0];
        res_index_r <= idx_ok ? idx_r[11:0] : 12'd0;
        res_range_r <= idx_ok;
        res_cell_r  <= '0;
      end
      ST_RMW: res_cell_r <= cell_new;
      default: ;
    endcase
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {2'b00, res_cell_r.count, res_cell_r.occupied, res_range_r, res_index_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  vohist_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .rd_data (st_rdata),
    .busy    (st_busy)
  );

endmodule

// ===== rtl/vohist_store.sv =====
// ----------------------------------------------------------------------------
// vohist_store
// cell store with registered read and a clearing sweep after reset
// ----------------------------------------------------------------------------
module vohist_store
  import vohist_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output cell_t      rd_data,
  output logic       busy
);

  cell_t              mem [MAX_CELLS];
  cell_t              rd_data_r;
  logic               clr_busy_r;
  logic [CELL_AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {CELL_AW{1'b1}}) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule
